// ===== sv/ssh_pkg.sv =====
package ssh_pkg;

  localparam int HASH_W      = 32;
  localparam int TOTAL_LEN_W = 16;
  localparam int COUNT_W     = 3;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    MIX_NONE,
    MIX_ONE,
    MIX_TWO,
    MIX_THREE,
    MIX_FULL
  } mix_kind_t;

  typedef struct packed {
    logic                   first;
    logic                   last;
    mix_kind_t              kind;
    logic [TOTAL_LEN_W-1:0] length;
    logic [HASH_W-1:0]      data;
  } ssh_item_t;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic              empty;
  } fin_item_t;

  function automatic mix_kind_t classify(input logic [COUNT_W-1:0] byte_count);
    mix_kind_t k;
    case (byte_count)
      3'd0: k = MIX_NONE;
      3'd1: k = MIX_ONE;
      3'd2: k = MIX_TWO;
      3'd3: k = MIX_THREE;
      default: k = MIX_FULL;
    endcase
    return k;
  endfunction

  function automatic logic [HASH_W-1:0] mix_word(input logic [HASH_W-1:0] h_in,
                                                 input logic [HASH_W-1:0] w,
                                                 input mix_kind_t kind);
    logic [HASH_W-1:0] lo;
    logic [HASH_W-1:0] hi;
    logic [HASH_W-1:0] s8a;
    logic [HASH_W-1:0] s8b;
    logic [HASH_W-1:0] t;
    logic [HASH_W-1:0] h;
    lo  = {16'd0, w[15:0]};
    hi  = {16'd0, w[31:16]};
    s8a = {{24{w[7]}}, w[7:0]};
    s8b = {{24{w[23]}}, w[23:16]};
    h   = h_in;
    t   = '0;
    case (kind)
      MIX_FULL: begin
        h = h + lo;
        t = (hi << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
      end
      MIX_THREE: begin
        h = h + lo;
        h = h ^ (h << 16);
        h = h ^ (s8b << 18);
        h = h + (h >> 11);
      end
      MIX_TWO: begin
        h = h + lo;
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      MIX_ONE: begin
        h = h + s8a;
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
      default: begin
        h = h_in;
      end
    endcase
    return h;
  endfunction

  function automatic logic [HASH_W-1:0] fin_step1(input logic [HASH_W-1:0] h_in);
    logic [HASH_W-1:0] h;
    h = h_in ^ (h_in << 3);
    h = h + (h >> 5);
    return h;
  endfunction

  function automatic logic [HASH_W-1:0] fin_step2(input logic [HASH_W-1:0] h_in);
    logic [HASH_W-1:0] h;
    h = h_in ^ (h_in << 4);
    h = h + (h >> 17);
    return h;
  endfunction

  function automatic logic [HASH_W-1:0] fin_step3(input logic [HASH_W-1:0] h_in);
    logic [HASH_W-1:0] h;
    h = h_in ^ (h_in << 25);
    h = h + (h >> 6);
    return h;
  endfunction

endpackage

// ===== sv/ssh_in_if.sv =====
interface ssh_in_if;
  import ssh_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   first_word;
  logic [TOTAL_LEN_W-1:0] total_length;
  logic [HASH_W-1:0]      data_word;
  logic [COUNT_W-1:0]     byte_count;
  logic                   last_word;

  modport source (
    output valid, first_word, total_length, data_word, byte_count, last_word,
    input  ready
  );

  modport sink (
    input  valid, first_word, total_length, data_word, byte_count, last_word,
    output ready
  );
endinterface

// ===== sv/ssh_out_if.sv =====
interface ssh_out_if;
  import ssh_pkg::*;

  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] hash_value;

  modport source (
    output valid, hash_value,
    input  ready
  );

  modport sink (
    input  valid, hash_value,
    output ready
  );
endinterface

// ===== sv/ssh_front.sv =====
module ssh_front (
  ssh_in_if.sink            in_chan,
  input  logic              full,
  output logic              push,
  output ssh_pkg::ssh_item_t push_item
);
  import ssh_pkg::*;

  assign in_chan.ready = !full;
  assign push          = in_chan.valid && !full;

  always_comb begin
    push_item.first  = in_chan.first_word;
    push_item.last   = in_chan.last_word;
    push_item.kind   = classify(in_chan.byte_count);
    push_item.length = in_chan.total_length;
    push_item.data   = in_chan.data_word;
  end
endmodule

// ===== sv/ssh_queue.sv =====
module ssh_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ssh_pkg::ssh_item_t push_item,
  output logic               full,
  output logic               q_valid,
  output ssh_pkg::ssh_item_t q_item,
  input  logic               pop
);
  import ssh_pkg::*;

  ssh_item_t          entries_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end
endmodule

// ===== sv/ssh_back.sv =====
module ssh_back #(
  parameter int LENGTH_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  ssh_pkg::ssh_item_t q_item,
  output logic               q_pop,
  output logic               fin_push,
  output ssh_pkg::fin_item_t fin_item,
  input  logic               fin_ready
);
  import ssh_pkg::*;

  localparam logic [HASH_W-1:0] LEN_MASK = HASH_W'((64'd1 << LENGTH_BITS) - 64'd1);

  logic [HASH_W-1:0]      running_hash_r, running_hash_nxt;
  logic [LENGTH_BITS-1:0] string_length_r, string_length_nxt;
  logic [HASH_W-1:0]      seed_len;
  logic [LENGTH_BITS-1:0] cur_len;
  logic [HASH_W-1:0]      base;
  logic [HASH_W-1:0]      mixed;

  always_comb begin
    seed_len = HASH_W'(q_item.length) & LEN_MASK;
    cur_len  = q_item.first ? seed_len[LENGTH_BITS-1:0] : string_length_r;
    base     = q_item.first ? seed_len : running_hash_r;
    mixed    = mix_word(base, q_item.data, q_item.kind);

    q_pop          = q_valid && (!q_item.last || fin_ready);
    fin_push       = q_valid && q_item.last && fin_ready;
    fin_item.hash  = mixed;
    fin_item.empty = (cur_len == '0);

    running_hash_nxt  = running_hash_r;
    string_length_nxt = string_length_r;
    if (q_pop) begin
      if (q_item.last) begin
        running_hash_nxt  = '0;
        string_length_nxt = '0;
      end else begin
        running_hash_nxt  = mixed;
        string_length_nxt = cur_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_hash_r  <= '0;
      string_length_r <= '0;
    end else begin
      running_hash_r  <= running_hash_nxt;
      string_length_r <= string_length_nxt;
    end
  end
endmodule

// ===== sv/ssh_finish.sv =====
module ssh_finish (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fin_push,
  input  ssh_pkg::fin_item_t fin_item,
  output logic               fin_ready,
  ssh_out_if.source          out_chan
);
  import ssh_pkg::*;

  logic              a_v_r, a_v_nxt;
  logic              b_v_r, b_v_nxt;
  logic              c_v_r, c_v_nxt;
  logic              o_v_r, o_v_nxt;
  fin_item_t         a_r, b_r, c_r;
  logic [HASH_W-1:0] o_hash_r;
  logic              a_ready, b_ready, c_ready, o_ready;

  always_comb begin
    o_ready = !o_v_r || out_chan.ready;
    c_ready = !c_v_r || o_ready;
    b_ready = !b_v_r || c_ready;
    a_ready = !a_v_r || b_ready;

    a_v_nxt = a_ready ? fin_push : a_v_r;
    b_v_nxt = b_ready ? a_v_r : b_v_r;
    c_v_nxt = c_ready ? b_v_r : c_v_r;
    o_v_nxt = o_ready ? c_v_r : o_v_r;
  end

  assign fin_ready           = a_ready;
  assign out_chan.valid      = o_v_r;
  assign out_chan.hash_value = o_hash_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
      c_v_r <= c_v_nxt;
      o_v_r <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && fin_push) begin
      a_r <= fin_item;
    end
    if (b_ready && a_v_r) begin
      b_r.hash  <= fin_step1(a_r.hash);
      b_r.empty <= a_r.empty;
    end
    if (c_ready && b_v_r) begin
      c_r.hash  <= fin_step2(b_r.hash);
      c_r.empty <= b_r.empty;
    end
    if (o_ready && c_v_r) begin
      o_hash_r <= c_r.empty ? '0 : fin_step3(c_r.hash);
    end
  end
endmodule

// ===== sv/superfast_string_hash.sv =====
// Streaming 32-bit string hash.
// in_chan takes one 32-bit word per item, earliest byte in bits 7:0. The first
// word of a string sets first_word and carries total_length; byte_count gives
// the valid bytes (4 on all but the last word, 0 to 4 on the last). The item
// with last_word set produces one result on out_chan: hash_value. An empty
// string (length 0) hashes to 0.
// Throughput: one item per cycle while the finish pipeline can take results, set
// by the mix round that updates the running hash.
// Path: a last word accepted on in_chan passes the queue, the mix stage and
// three finish stages before its result shows on out_chan.
// A two-entry queue separates the input side from the mix stage, so in_chan
// keeps taking items while results wait; when out_chan stalls the finish
// pipeline fills, then the queue, and only then in_chan.ready drops.
// Reset (rst_n low, synchronous) empties the queue and pipeline and clears the
// running hash and stored length.
module superfast_string_hash #(
  parameter int LENGTH_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ssh_in_if.sink    in_chan,
  ssh_out_if.source out_chan
);
  import ssh_pkg::*;

  logic      push;
  ssh_item_t push_item;
  logic      full;
  logic      q_valid;
  ssh_item_t q_item;
  logic      q_pop;
  logic      fin_push;
  fin_item_t fin_item;
  logic      fin_ready;

  ssh_front u_front (
    .in_chan   (in_chan),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  ssh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (q_pop)
  );

  ssh_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .fin_push  (fin_push),
    .fin_item  (fin_item),
    .fin_ready (fin_ready)
  );

  ssh_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin_push  (fin_push),
    .fin_item  (fin_item),
    .fin_ready (fin_ready),
    .out_chan  (out_chan)
  );
endmodule

// ===== sv/ssh_checker.sv =====
module ssh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_word,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_hash_value
);
  logic [3:0] pending_r, pending_nxt;
  logic       in_take;
  logic       out_take;

  assign in_take  = in_valid && in_ready && in_last_word;
  assign out_take = out_valid && out_ready;

  always_comb begin
    pending_nxt = pending_r + 4'(in_take) - 4'(out_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_opens_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hash_value))
    else $error("stalled result changed or dropped");

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 4'd0)
    else $error("result without an outstanding last word");
endmodule

bind superfast_string_hash ssh_checker u_ssh_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .in_last_word   (in_chan.last_word),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_hash_value (out_chan.hash_value)
);
